// ----- src/assert_macros.svh -----
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (con)) \
		else $error("assertion lbl failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, pre, con) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (con)) \
		else $error("assertion lbl failed");

`endif

// ----- src/mna_pkg.sv -----
// Package with the codes, constants and helper functions of the arpeggiator.
`default_nettype none
package mna_pkg;

	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_TICK    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_UP     = 2'd0,
		MODE_DOWN   = 2'd1,
		MODE_UPDOWN = 2'd2,
		MODE_RANDOM = 2'd3
	} mode_t;

	localparam logic [2:0] REG_ENABLE      = 3'd0;
	localparam logic [2:0] REG_STEP_PERIOD = 3'd1;
	localparam logic [2:0] REG_ARP_MODE    = 3'd2;
	localparam logic [2:0] REG_OCTAVE_SPAN = 3'd3;
	localparam logic [2:0] REG_SINGLE_PASS = 3'd4;

	localparam int          LFSR_W       = 16;
	localparam logic [15:0] LFSR_SEED    = 16'hACE1;
	localparam logic [15:0] LFSR_MASK    = 16'hB400;
	localparam logic [6:0]  VEL_ON       = 7'd64;
	localparam logic [6:0]  VEL_OFF      = 7'd0;
	localparam logic [6:0]  KEY_MAX      = 7'd127;
	localparam int          OCTAVE_SEMITONES = 12;
	localparam logic [17:0] PERIOD_RESET = 18'd24000;

	function automatic logic [6:0] transpose(input logic [6:0] k, input logic [1:0] oct);
		logic [7:0] sum;
		sum = {1'b0, k} + 8'(oct) * 8'(OCTAVE_SEMITONES);
		return (sum > {1'b0, KEY_MAX}) ? KEY_MAX : sum[6:0];
	endfunction

	function automatic logic [15:0] lfsr_next(input logic [15:0] v);
		return (v >> 1) ^ (v[0] ? LFSR_MASK : 16'h0000);
	endfunction

endpackage
`default_nettype wire

// ----- src/midi_note_arpeggiator.sv -----
// Top level of the MIDI note arpeggiator.
// Input beats carry op and key: press, release or one sample tick. Result
// beats carry event_kind, out_key, velocity and last. Both channels use
// valid and ready; in_ready is high while the sequencer is idle, and it
// stays high while a finished result still waits in the output register.
// Held keys live in a synchronous memory that the sequencer reads,
// compares and writes back one entry at a time. After a press the
// sequencer searches (scan read, check) and shifts (shift read, write)
// before it places the key; after a release it searches and shifts.
// A tick that fires a step keeps it busy through the step states, with
// an extra state when the chosen note repeats and a wait on the remainder
// unit in random mode; other ticks leave the sequencer idle.
// A step yields up to two result beats, the note-off first. If the
// receiver stalls, the sequencer waits before loading the next result and
// takes no new input beat meanwhile. Reset clears the held count, the
// counters, the output valid flag and reloads the random seed; the memory
// itself is not cleared. Configuration writes are registered.
`default_nettype none
module midi_note_arpeggiator #(
	parameter int KEY_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [17:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [6:0]  key,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             event_kind,
	output logic [6:0]       out_key,
	output logic [6:0]       velocity,
	output logic             last
);
	import mna_pkg::*;

	localparam int CW = $clog2(KEY_SLOTS + 1);
	localparam int IW = $clog2(KEY_SLOTS);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b000000000001,
		S_SCAN_RD  = 12'b000000000010,
		S_SCAN_CHK = 12'b000000000100,
		S_SHIFT_RD = 12'b000000001000,
		S_SHIFT_WR = 12'b000000010000,
		S_PLACE    = 12'b000000100000,
		S_STEP_OFF = 12'b000001000000,
		S_STEP_MOD = 12'b000010000000,
		S_STEP_RD  = 12'b000100000000,
		S_STEP_CHK = 12'b001000000000,
		S_STEP_ALT = 12'b010000000000,
		S_STEP_ON  = 12'b100000000000
	} state_t;

	state_t      state_q;
	logic        enable_q, single_q;
	logic [17:0] period_q, smp_q;
	logic [1:0]  mode_q, span_q, oct_q;
	logic [CW-1:0] count_q, j_q, pos_q;
	logic [IW-1:0] idx_q;
	logic        dir_q, rp_q, rm_q;
	logic [6:0]  played_q, sounding_q, k_q, key_q;
	logic [15:0] lfsr_q;

	logic        ov_q, okind_q, olast_q;
	logic [6:0]  okey_q, ovel_q;

	logic          mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [6:0]    mem_wdata, mem_rdata;
	logic          mod_start, mod_done;
	logic [CW-1:0] mod_rem;

	logic [CW-1:0] top, idx_ext, j_dn, j_up;
	logic [IW-1:0] idx_move, sel, alt;
	logic          dir_move, out_free, in_fire, out_load;
	logic [1:0]    oct_range;
	logic [15:0]   lfsr_n;
	logic [6:0]    tkey;

	assign top      = count_q - 1'b1;
	assign idx_ext  = CW'(idx_q);
	assign j_dn     = j_q - 1'b1;
	assign j_up     = j_q + 1'b1;
	assign sel      = (idx_ext < top) ? idx_q : top[IW-1:0];
	assign alt      = (count_q == CW'(1)) ? '0 : IW'(1);
	assign out_free = !ov_q || out_ready;
	assign out_load = ((state_q == S_STEP_OFF) && rp_q && out_free) ||
		((state_q == S_STEP_ON) && out_free);
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign oct_range = (span_q != 2'd0) ? span_q - 2'd1 : 2'd0;
	assign lfsr_n   = lfsr_next(lfsr_q);
	assign tkey     = transpose(key_q, oct_q);
	assign mod_start = (state_q == S_STEP_OFF) && (!rp_q || out_free) &&
		(count_q != '0) && (mode_q == MODE_RANDOM);

	always_comb begin
		idx_move = idx_q;
		dir_move = dir_q;
		unique case (mode_q)
			MODE_UP:   idx_move = (idx_ext < top) ? idx_q + 1'b1 : '0;
			MODE_DOWN: idx_move = (idx_q != '0) ? idx_q - 1'b1 : top[IW-1:0];
			MODE_UPDOWN: begin
				if (dir_q) begin
					idx_move = (idx_q != IW'(KEY_SLOTS - 1)) ? idx_q + 1'b1 : idx_q;
				end else begin
					idx_move = (idx_q != '0) ? idx_q - 1'b1 : '0;
				end
				if (idx_move == '0 || CW'(idx_move) >= top) begin
					dir_move = !dir_q;
				end
			end
			MODE_RANDOM: idx_move = idx_q;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = j_q[IW-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = j_q[IW-1:0];
		unique case (state_q)
			S_SHIFT_RD: mem_raddr = rm_q ? j_up[IW-1:0] : j_dn[IW-1:0];
			S_SHIFT_WR: mem_we = 1'b1;
			S_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[IW-1:0];
				mem_wdata = k_q;
			end
			S_STEP_RD:  mem_raddr = sel;
			S_STEP_CHK: mem_raddr = alt;
			default: mem_raddr = j_q[IW-1:0];
		endcase
	end

	mna_keymem #(.DEPTH(KEY_SLOTS), .AW(IW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	mna_modulo #(.DSW(CW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (lfsr_n),
		.divisor  (count_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			enable_q   <= 1'b0;
			period_q   <= PERIOD_RESET;
			mode_q     <= MODE_UP;
			span_q     <= 2'd1;
			single_q   <= 1'b0;
			count_q    <= '0;
			idx_q      <= '0;
			dir_q      <= 1'b1;
			oct_q      <= 2'd0;
			smp_q      <= '0;
			played_q   <= '0;
			sounding_q <= '0;
			rp_q       <= 1'b0;
			lfsr_q     <= LFSR_SEED;
			ov_q       <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENABLE:      enable_q <= cfg_data[0];
					REG_STEP_PERIOD: period_q <= cfg_data;
					REG_ARP_MODE: begin
						mode_q <= cfg_data[1:0];
						idx_q  <= '0;
					end
					REG_OCTAVE_SPAN: span_q   <= cfg_data[1:0];
					REG_SINGLE_PASS: single_q <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && enable_q) begin
						j_q  <= '0;
						k_q  <= key;
						rm_q <= (op == OP_RELEASE);
						if (op == OP_PRESS || op == OP_RELEASE) begin
							state_q <= S_SCAN_RD;
						end else if (op == OP_TICK) begin
							smp_q <= (smp_q >= period_q) ? '0 : smp_q + 1'b1;
							if (smp_q == 18'd1) begin
								if (count_q != '0 && idx_ext == top) begin
									oct_q <= (oct_q < oct_range) ? oct_q + 2'd1 : 2'd0;
								end
								state_q <= S_STEP_OFF;
							end
						end
					end
				end
				S_SCAN_RD: begin
					if (j_q == count_q) begin
						pos_q   <= count_q;
						if (rm_q || count_q == CW'(KEY_SLOTS)) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SHIFT_RD;
						end
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					if (rm_q ? (mem_rdata == k_q) : (mem_rdata >= k_q)) begin
						pos_q <= j_q;
						if (mem_rdata == k_q && !rm_q) begin
							state_q <= S_IDLE;
						end else if (!rm_q && count_q == CW'(KEY_SLOTS)) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= rm_q ? j_q : count_q;
							state_q <= S_SHIFT_RD;
						end
					end else begin
						j_q     <= j_up;
						state_q <= S_SCAN_RD;
					end
				end
				S_SHIFT_RD: begin
					if (rm_q) begin
						if (j_up >= count_q) begin
							count_q <= top;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SHIFT_WR;
						end
					end else if (j_q == pos_q) begin
						state_q <= S_PLACE;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					j_q     <= rm_q ? j_up : j_dn;
					state_q <= S_SHIFT_RD;
				end
				S_PLACE: begin
					count_q <= count_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_STEP_OFF: begin
					if (!rp_q || out_free) begin
						if (rp_q) begin
							okind_q <= 1'b0;
							okey_q  <= sounding_q;
							ovel_q  <= VEL_OFF;
							olast_q <= (count_q == '0);
							rp_q    <= 1'b0;
						end
						if (count_q == '0) begin
							state_q <= S_IDLE;
						end else if (mode_q == MODE_RANDOM) begin
							lfsr_q  <= lfsr_n;
							state_q <= S_STEP_MOD;
						end else begin
							idx_q   <= idx_move;
							dir_q   <= dir_move;
							state_q <= S_STEP_RD;
						end
					end
				end
				S_STEP_MOD: begin
					if (mod_done) begin
						idx_q   <= mod_rem[IW-1:0];
						state_q <= S_STEP_RD;
					end
				end
				S_STEP_RD: state_q <= S_STEP_CHK;
				S_STEP_CHK: begin
					key_q   <= mem_rdata;
					state_q <= (mem_rdata == played_q) ? S_STEP_ALT : S_STEP_ON;
				end
				S_STEP_ALT: begin
					key_q   <= mem_rdata;
					state_q <= S_STEP_ON;
				end
				S_STEP_ON: begin
					if (out_free) begin
						okind_q    <= 1'b1;
						okey_q     <= tkey;
						ovel_q     <= VEL_ON;
						olast_q    <= 1'b1;
						played_q   <= key_q;
						sounding_q <= tkey;
						rp_q       <= 1'b1;
						if (single_q && idx_ext == top) begin
							count_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign event_kind = okind_q;
	assign out_key    = okey_q;
	assign velocity   = ovel_q;
	assign last       = olast_q;
endmodule
`default_nettype wire

// ----- src/mna_keymem.sv -----
// Held-key memory with one write port and one registered read port.
`default_nettype none
module mna_keymem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [6:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [6:0]    rdata
);
	logic [6:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- src/mna_modulo.sv -----
// Restoring remainder unit, one dividend bit per cycle while busy.
`default_nettype none
module mna_modulo #(
	parameter int DSW = 5
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [15:0]    dividend,
	input  wire logic [DSW-1:0] divisor,
	output logic                done,
	output logic      [DSW-1:0] rem
);
	import mna_pkg::*;

	localparam int NW = $clog2(LFSR_W + 1);

	logic [NW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [15:0]    dvd_q;
	logic [DSW-1:0] rem_q;
	logic [DSW:0]   trial;
	logic [DSW:0]   rem_n;

	assign trial = {rem_q, dvd_q[15]};
	assign rem_n = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(LFSR_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_n[DSW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ----- src/mna_checker.sv -----
// Port-level checker for the arpeggiator and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module mna_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       event_kind,
	input wire logic [6:0] out_key,
	input wire logic [6:0] velocity,
	input wire logic       last
);
	// A note-on always carries the fixed velocity and closes its tick.
	`ASSERT_IMPLIES(a_on_vel, clk, arst_n, out_valid && event_kind, velocity == 7'd64)
	`ASSERT_IMPLIES(a_off_vel, clk, arst_n, out_valid && !event_kind, velocity == 7'd0)
	`ASSERT_IMPLIES(a_on_last, clk, arst_n, out_valid && event_kind, last)
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_key))
endmodule

bind midi_note_arpeggiator mna_checker u_chk (.*);
`default_nettype wire

// ----- bench/midi_note_arpeggiator_tb.sv -----
// Self-checking testbench for the MIDI note arpeggiator, with a cycle-free model of its behavior.
`default_nettype none
module midi_note_arpeggiator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mna_pkg::*;

	localparam int SLOTS = 16;
	localparam int DOG_LIMIT = 20000;
	localparam int SETTLE = 80;

	typedef struct packed {
		logic       kind;
		logic [6:0] note;
		logic [6:0] vel;
		logic       fin;
	} note_evt_t;

	typedef struct {
		op_t        op;
		logic [6:0] key;
		bit         known;
		logic [6:0] xkey;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [17:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [6:0]  key;
	logic        out_valid;
	logic        out_ready;
	logic        event_kind;
	logic [6:0]  out_key;
	logic [6:0]  velocity;
	logic        last;

	midi_note_arpeggiator u_dut (.*);

	// Model state and configuration.
	logic        m_enable;
	logic [17:0] m_period;
	mode_t       m_mode;
	logic [1:0]  m_span;
	logic        m_single;
	logic [6:0]  m_held [SLOTS];
	int          m_count;
	int          m_idx;
	logic        m_up;
	int          m_oct;
	logic [17:0] m_ctr;
	logic [6:0]  m_played;
	logic [6:0]  m_sounding;
	logic        m_pending;
	logic [15:0] m_lfsr;

	note_evt_t   pending_notes[$];
	int          errors;
	int          quiet_cycles;
	int          stall_pct;
	int          idle_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic model_reset();
		m_enable = 1'b0;
		m_period = PERIOD_RESET;
		m_mode = MODE_UP;
		m_span = 2'd1;
		m_single = 1'b0;
		m_count = 0;
		m_idx = 0;
		m_up = 1'b1;
		m_oct = 0;
		m_ctr = '0;
		m_played = '0;
		m_sounding = '0;
		m_pending = 1'b0;
		m_lfsr = LFSR_SEED;
	endtask

	task automatic model_write(input logic [2:0] idx, input logic [17:0] val);
		case (idx)
			REG_ENABLE: m_enable = val[0];
			REG_STEP_PERIOD: m_period = val;
			REG_ARP_MODE: begin
				m_mode = mode_t'(val[1:0]);
				m_idx = 0;
			end
			REG_OCTAVE_SPAN: m_span = val[1:0];
			REG_SINGLE_PASS: m_single = val[0];
			default: ;
		endcase
	endtask

	task automatic fire_step();
		note_evt_t evs[2];
		int n;
		int top;
		int span_top;
		int sel;
		int sum;
		logic [6:0] k;
		n = 0;
		if (m_count > 0 && m_idx == m_count - 1) begin
			span_top = (m_span > 0) ? m_span - 1 : 0;
			m_oct = (m_oct < span_top) ? m_oct + 1 : 0;
		end
		if (m_pending) begin
			evs[n] = '{1'b0, m_sounding, VEL_OFF, 1'b0};
			n++;
			m_pending = 1'b0;
		end
		if (m_count > 0) begin
			top = m_count - 1;
			case (m_mode)
				MODE_UP: m_idx = (m_idx < top) ? m_idx + 1 : 0;
				MODE_DOWN: m_idx = (m_idx > 0) ? m_idx - 1 : top;
				MODE_UPDOWN: begin
					if (m_up)
						m_idx = (m_idx < SLOTS - 1) ? m_idx + 1 : SLOTS - 1;
					else
						m_idx = (m_idx > 0) ? m_idx - 1 : 0;
					if (m_idx == 0 || m_idx >= top)
						m_up = ~m_up;
				end
				default: begin
					m_lfsr = (m_lfsr >> 1) ^ (m_lfsr[0] ? LFSR_MASK : 16'h0000);
					m_idx = int'(m_lfsr) % m_count;
				end
			endcase
			sel = (m_idx < top) ? m_idx : top;
			k = m_held[sel];
			if (k == m_played)
				k = m_held[(top < 1) ? top : 1];
			m_played = k;
			sum = int'(k) + m_oct * OCTAVE_SEMITONES;
			m_sounding = (sum > 127) ? KEY_MAX : 7'(sum);
			evs[n] = '{1'b1, m_sounding, VEL_ON, 1'b0};
			n++;
			if (m_single && m_idx == top)
				m_count = 0;
			m_pending = 1'b1;
		end
		if (n > 0)
			evs[n-1].fin = 1'b1;
		for (int i = 0; i < n; i++)
			pending_notes = {pending_notes, evs[i]};
	endtask

	task automatic model_item(input op_t o, input logic [6:0] k);
		int pos;
		if (!m_enable)
			return;
		case (o)
			OP_PRESS: begin
				pos = 0;
				while (pos < m_count && m_held[pos] < k)
					pos++;
				if (!(pos < m_count && m_held[pos] == k) && m_count < SLOTS) begin
					for (int j = m_count; j > pos; j--)
						m_held[j] = m_held[j-1];
					m_held[pos] = k;
					m_count++;
				end
			end
			OP_RELEASE: begin
				pos = 0;
				while (pos < m_count && m_held[pos] != k)
					pos++;
				if (pos < m_count) begin
					for (int j = pos; j + 1 < m_count; j++)
						m_held[j] = m_held[j+1];
					m_count--;
				end
			end
			OP_TICK: begin
				if (m_ctr == 18'd1)
					fire_step();
				m_ctr = (m_ctr >= m_period) ? 18'd0 : m_ctr + 18'd1;
			end
			default: ;
		endcase
	endtask

	task automatic send_beat(input op_t o, input logic [6:0] k);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op = o;
		key = k;
		do
			@(posedge clk);
		while (!in_ready);
		model_item(o, k);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending_notes.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		model_write(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_notes.size() == 0) begin
				report($sformatf("unexpected beat key %0d", out_key));
			end else begin
				note_evt_t want;
				want = pending_notes.pop_front();
				if (event_kind !== want.kind)
					report($sformatf("event_kind %b, want %b", event_kind, want.kind));
				if (out_key !== want.note)
					report($sformatf("out_key %0d, want %0d", out_key, want.note));
				if (velocity !== want.vel)
					report($sformatf("velocity %0d, want %0d", velocity, want.vel));
				if (last !== want.fin)
					report($sformatf("last %b, want %b", last, want.fin));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= DOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	stim_row_t directed[] = '{
		'{OP_PRESS, 7'd60, 1'b0, 7'd0},
		'{OP_PRESS, 7'd127, 1'b0, 7'd0},
		'{OP_PRESS, 7'd0, 1'b0, 7'd0},
		'{OP_PRESS, 7'd60, 1'b0, 7'd0},
		'{OP_RELEASE, 7'd5, 1'b0, 7'd0},
		'{OP_NONE, 7'd127, 1'b0, 7'd0},
		'{OP_TICK, 7'd0, 1'b0, 7'd0},
		'{OP_TICK, 7'd0, 1'b1, 7'd60},
		'{OP_TICK, 7'd0, 1'b0, 7'd0},
		'{OP_TICK, 7'd0, 1'b0, 7'd0},
		'{OP_TICK, 7'd127, 1'b1, 7'd127},
		'{OP_RELEASE, 7'd127, 1'b0, 7'd0},
		'{OP_RELEASE, 7'd0, 1'b0, 7'd0},
		'{OP_TICK, 7'd0, 1'b0, 7'd0},
		'{OP_TICK, 7'd0, 1'b0, 7'd0},
		'{OP_TICK, 7'd0, 1'b0, 7'd0},
		'{OP_RELEASE, 7'd60, 1'b0, 7'd0},
		'{OP_TICK, 7'd0, 1'b0, 7'd0},
		'{OP_TICK, 7'd0, 1'b0, 7'd0},
		'{OP_TICK, 7'd0, 1'b0, 7'd0}
	};

	initial begin
		int r;
		int count;
		op_t o;
		logic [6:0] k;
		note_evt_t got;
		errors = 0;
		quiet_cycles = 0;
		stall_pct = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_PRESS;
		key = '0;
		out_ready = 1'b1;
		model_reset();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(REG_ENABLE, 18'd1);
		write_reg(REG_STEP_PERIOD, 18'd2);
		foreach (directed[i]) begin
			send_beat(directed[i].op, directed[i].key);
			if (directed[i].known) begin
				if (pending_notes.size() == 0) begin
					report($sformatf("row %0d predicted no note-on", i));
				end else begin
					got = pending_notes[$];
					if (got.note != directed[i].xkey || !got.kind)
						report($sformatf("row %0d predicted wrong note-on", i));
				end
			end
		end
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 80 : 7) : 0;
			stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 2) ? 80 : 7) : 0;
			write_reg(REG_ENABLE, (ph == 5) ? 18'd0 : 18'd1);
			write_reg(REG_STEP_PERIOD, (ph == 1) ? 18'd1 : (ph == 7) ? 18'd262143 :
				18'($urandom_range(1, 6)));
			write_reg(REG_ARP_MODE, 18'(ph % 4));
			write_reg(REG_OCTAVE_SPAN, (ph == 2) ? 18'd3 : (ph == 3) ? 18'd1 :
				18'($urandom_range(1, 3)));
			write_reg(REG_SINGLE_PASS, 18'(ph % 3 == 2));
			count = (ph == 5 || ph == 7) ? 40 : 140;
			for (int n = 0; n < count; n++) begin
				r = $urandom_range(99);
				o = (r < 30) ? OP_PRESS : (r < 50) ? OP_RELEASE : (r < 97) ? OP_TICK : OP_NONE;
				k = ($urandom_range(99) < 70) ? 7'($urandom_range(55, 70)) :
					7'($urandom_range(127));
				send_beat(o, k);
			end
			drain();
		end

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/mna_pkg.sv
src/mna_keymem.sv
src/mna_modulo.sv
src/midi_note_arpeggiator.sv
src/mna_checker.sv
bench/midi_note_arpeggiator_tb.sv
